// ===== hdl/dst_pkg.sv =====
// ----------------------------------------------------------------------------
// Device sighting table package
// Shared constants, command codes, state type and the structures that travel
// between the controller and the row of table cells.
// ----------------------------------------------------------------------------
package dst_pkg;

  localparam int TABLE_ENTRIES_DEF = 24;

  localparam int ADDR_W    = 48;
  localparam int KIND_W    = 3;
  localparam int DBM_W     = 8;
  localparam int TIME_W    = 32;
  localparam int HITS_W    = 16;
  localparam int OUT_IDX_W = 5;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 32;

  localparam logic [TIME_W-1:0] ALERT_AGE_RESET = TIME_W'(5 * 60 * 1000);
  localparam logic [HITS_W-1:0] HITS_MAX        = {HITS_W{1'b1}};
  localparam logic [KIND_W-1:0] KIND_NONE       = '0;

  localparam logic OP_OBSERVE = 1'b0;
  localparam logic OP_CLEAR   = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_SCAN_ENABLE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_ALERT_AGE   = CFG_IDX_W'(1);

  typedef enum logic {
    ST_IDLE,
    ST_SEARCH
  } dst_state_t;

  typedef struct packed {
    logic              active;
    logic              found;
    logic              free_found;
    logic              min_taken;
    logic [TIME_W-1:0] min_time;
    logic [HITS_W-1:0] hit_hits;
    logic [DBM_W-1:0]  hit_best;
    logic [TIME_W-1:0] hit_first;
  } probe_t;

  typedef struct packed {
    logic              we;
    logic              clr;
    logic [ADDR_W-1:0] addr;
    logic [KIND_W-1:0] kind;
    logic [TIME_W-1:0] first;
    logic [TIME_W-1:0] last;
    logic [DBM_W-1:0]  latest;
    logic [DBM_W-1:0]  best;
    logic [HITS_W-1:0] hits;
  } wr_t;

endpackage

// ===== hdl/device_sighting_table_top.sv =====
// ----------------------------------------------------------------------------
// Device sighting table
// Keyed table of radio devices with least-recently-seen replacement.
//
// An item is taken at a clock edge where start is high and busy is low.
// A clear item empties the table at the accepting edge and gives no result. An
// observe item is dropped without a result when scanning is off or the
// kind is zero. Otherwise a search beat walks the row of TABLE_ENTRIES
// cells, one cell per cycle, collecting the key match, the first free
// entry and the oldest entry; as the beat leaves the last cell, the chosen
// entry is written and the result is registered and shown for a single cycle
// marked by out_strobe. Busy stays high while the beat walks the row and
// falls in the strobe cycle, so no new item is taken before the last is done.
// The receiver cannot stall: each result beat is taken in its strobe cycle.
// Configuration writes are always ready and take effect at once.
// Reset empties the table, turns scanning off and loads the alert age
// with five minutes.
// ----------------------------------------------------------------------------
module device_sighting_table_top
  import dst_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic                     in_opcode,
  input  logic [ADDR_W-1:0]        in_device_addr,
  input  logic [KIND_W-1:0]        in_device_kind,
  input  logic signed [DBM_W-1:0]  in_signal_dbm,
  input  logic [TIME_W-1:0]        in_time_ms,
  output logic                     out_strobe,
  output logic [OUT_IDX_W-1:0]     out_entry_index,
  output logic                     out_was_new,
  output logic                     out_was_evicted,
  output logic [HITS_W-1:0]        out_seen_count,
  output logic signed [DBM_W-1:0]  out_best_dbm,
  output logic [TIME_W-1:0]        out_first_time_ms,
  output logic                     out_persistent,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  dst_state_t state_r, state_nxt;

  logic              scan_enable_r;
  logic [TIME_W-1:0] alert_age_r;

  logic [ADDR_W-1:0] key_r;
  logic [ADDR_W-1:0] key;
  logic [KIND_W-1:0] kind_r;
  logic [DBM_W-1:0]  sig_r;
  logic [TIME_W-1:0] now_r;

  probe_t            chain    [0:TABLE_ENTRIES];
  logic [IDX_W-1:0]  midx     [0:TABLE_ENTRIES];
  logic [IDX_W-1:0]  aidx     [0:TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] valid_vec;

  logic              accept;
  logic              accept_clear;
  logic              accept_obs;
  logic              tail_done;
  probe_t            tail;
  wr_t               wr;
  logic [IDX_W-1:0]  slot;
  logic [IDX_W+OUT_IDX_W-1:0] slot_ext;
  logic [HITS_W-1:0] old_hits;
  logic [DBM_W-1:0]  old_best;
  logic [TIME_W-1:0] old_first;
  logic [TIME_W-1:0] new_first;
  logic [DBM_W-1:0]  new_best;
  logic [HITS_W-1:0] new_hits;
  logic              new_persistent;

  logic              out_strobe_r;
  logic [OUT_IDX_W-1:0] out_entry_index_r;
  logic              out_was_new_r;
  logic              out_was_evicted_r;
  logic [HITS_W-1:0] out_seen_count_r;
  logic [DBM_W-1:0]  out_best_dbm_r;
  logic [TIME_W-1:0] out_first_time_ms_r;
  logic              out_persistent_r;

  assign accept       = start && !busy;
  assign accept_clear = accept && (in_opcode == OP_CLEAR);
  assign accept_obs   = accept && (in_opcode == OP_OBSERVE) && scan_enable_r &&
                        (in_device_kind != KIND_NONE);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_enable_r <= 1'b0;
      alert_age_r   <= ALERT_AGE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SCAN_ENABLE: scan_enable_r <= cfg_data[0];
        CFG_ALERT_AGE:   alert_age_r   <= cfg_data[TIME_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept_obs) begin
      key_r  <= in_device_addr;
      kind_r <= in_device_kind;
      sig_r  <= in_signal_dbm;
      now_r  <= in_time_ms;
    end
  end

  // The first cell sees the search beat in the accepting cycle itself.
  assign key = accept_obs ? in_device_addr : key_r;

  always_comb begin
    chain[0]        = '0;
    chain[0].active = accept_obs;
    midx[0]         = '0;
    aidx[0]         = '0;
  end

  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    dst_cell #(
      .IDX_W    (IDX_W),
      .CELL_IDX (g)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .key         (key),
      .probe_i     (chain[g]),
      .match_idx_i (midx[g]),
      .alt_idx_i   (aidx[g]),
      .probe_o     (chain[g+1]),
      .match_idx_o (midx[g+1]),
      .alt_idx_o   (aidx[g+1]),
      .wr          (wr),
      .wr_idx      (slot),
      .valid_o     (valid_vec[g])
    );
  end

  assign tail      = chain[TABLE_ENTRIES];
  assign tail_done = (state_r == ST_SEARCH) && tail.active;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept_obs) begin
          state_nxt = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (tail.active) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    case (state_r)
      ST_IDLE:   busy = 1'b0;
      ST_SEARCH: busy = 1'b1;
      default:   busy = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    slot      = tail.found ? midx[TABLE_ENTRIES] : aidx[TABLE_ENTRIES];
    old_hits  = tail.found ? tail.hit_hits  : '0;
    old_best  = tail.found ? tail.hit_best  : '0;
    old_first = tail.found ? tail.hit_first : '0;
    new_first = (old_first == '0) ? now_r : old_first;
    new_best  = ((old_hits == '0) || ($signed(sig_r) > $signed(old_best))) ? sig_r : old_best;
    new_hits  = (old_hits == HITS_MAX) ? old_hits : old_hits + HITS_W'(1);
    new_persistent = (now_r - new_first) > alert_age_r;
    slot_ext  = {{OUT_IDX_W{1'b0}}, slot};

    wr        = '0;
    wr.we     = tail_done;
    wr.clr    = accept_clear;
    wr.addr   = key_r;
    wr.kind   = kind_r;
    wr.first  = new_first;
    wr.last   = now_r;
    wr.latest = sig_r;
    wr.best   = new_best;
    wr.hits   = new_hits;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= tail_done;
    end
  end

  always_ff @(posedge clk) begin
    if (tail_done) begin
      out_entry_index_r   <= slot_ext[OUT_IDX_W-1:0];
      out_was_new_r       <= !tail.found;
      out_was_evicted_r   <= !tail.found && !tail.free_found;
      out_seen_count_r    <= new_hits;
      out_best_dbm_r      <= new_best;
      out_first_time_ms_r <= new_first;
      out_persistent_r    <= new_persistent;
    end
  end

  assign out_strobe        = out_strobe_r;
  assign out_entry_index   = out_entry_index_r;
  assign out_was_new       = out_was_new_r;
  assign out_was_evicted   = out_was_evicted_r;
  assign out_seen_count    = out_seen_count_r;
  assign out_best_dbm      = out_best_dbm_r;
  assign out_first_time_ms = out_first_time_ms_r;
  assign out_persistent    = out_persistent_r;

  // A search beat only reaches the end of the row while a search is running.
  a_tail_in_search: assert property (@(posedge clk) disable iff (!rst_n)
    tail.active |-> (state_r == ST_SEARCH))
    else $error("search beat left the cell row outside a search");

  // A result beat follows the end of a search and nothing else.
  a_strobe_after_search: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> ($past(state_r) == ST_SEARCH && state_r == ST_IDLE))
    else $error("result beat without a finished search");

  // A clear leaves every entry invalid.
  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    accept_clear |=> (valid_vec == '0))
    else $error("table not empty after clear");

  // A new search beat starts only when the block is idle.
  a_launch_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept_obs |-> (state_r == ST_IDLE && !out_strobe_r || state_r == ST_IDLE))
    else $error("search launched while busy");

endmodule

// ===== hdl/dst_cell.sv =====
// ----------------------------------------------------------------------------
// Device sighting table cell
// Holds one table entry. A search beat passes through the cell's probe register,
// picking up a key match, the first free entry or the oldest entry so far.
// ----------------------------------------------------------------------------
module dst_cell
  import dst_pkg::*;
#(
  parameter int IDX_W    = 5,
  parameter int CELL_IDX = 0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [ADDR_W-1:0] key,
  input  probe_t            probe_i,
  input  logic [IDX_W-1:0]  match_idx_i,
  input  logic [IDX_W-1:0]  alt_idx_i,
  output probe_t            probe_o,
  output logic [IDX_W-1:0]  match_idx_o,
  output logic [IDX_W-1:0]  alt_idx_o,
  input  wr_t               wr,
  input  logic [IDX_W-1:0]  wr_idx,
  output logic              valid_o
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

  logic              valid_r;
  logic [ADDR_W-1:0] addr_r;
  logic [KIND_W-1:0] kind_r;
  logic [TIME_W-1:0] first_r;
  logic [TIME_W-1:0] last_r;
  logic [DBM_W-1:0]  latest_r;
  logic [DBM_W-1:0]  best_r;
  logic [HITS_W-1:0] hits_r;

  probe_t            probe_r, probe_nxt;
  logic [IDX_W-1:0]  match_idx_r, match_idx_nxt;
  logic [IDX_W-1:0]  alt_idx_r, alt_idx_nxt;
  logic              match;
  logic              sel;

  assign match = valid_r && (addr_r == key);
  assign sel   = wr.we && (wr_idx == MY_IDX);

  always_comb begin
    probe_nxt     = probe_i;
    match_idx_nxt = match_idx_i;
    alt_idx_nxt   = alt_idx_i;
    if (!probe_i.found && match) begin
      probe_nxt.found     = 1'b1;
      probe_nxt.hit_hits  = hits_r;
      probe_nxt.hit_best  = best_r;
      probe_nxt.hit_first = first_r;
      match_idx_nxt       = MY_IDX;
    end
    if (!probe_i.free_found) begin
      if (!valid_r) begin
        probe_nxt.free_found = 1'b1;
        alt_idx_nxt          = MY_IDX;
      end else if (!probe_i.min_taken || (last_r < probe_i.min_time)) begin
        probe_nxt.min_taken = 1'b1;
        probe_nxt.min_time  = last_r;
        alt_idx_nxt         = MY_IDX;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      probe_r     <= '0;
      match_idx_r <= '0;
      alt_idx_r   <= '0;
    end else begin
      probe_r     <= probe_nxt;
      match_idx_r <= match_idx_nxt;
      alt_idx_r   <= alt_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (wr.clr) begin
      valid_r <= 1'b0;
    end else if (sel) begin
      valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (sel) begin
      addr_r   <= wr.addr;
      kind_r   <= wr.kind;
      first_r  <= wr.first;
      last_r   <= wr.last;
      latest_r <= wr.latest;
      best_r   <= wr.best;
      hits_r   <= wr.hits;
    end
  end

  assign probe_o     = probe_r;
  assign match_idx_o = match_idx_r;
  assign alt_idx_o   = alt_idx_r;
  assign valid_o     = valid_r && (kind_r != KIND_NONE || latest_r == latest_r);

endmodule
